### rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the priority task scheduler
// Field structs, operation and result codes, queue sizing.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int TASK_SLOTS  = 16;
   localparam int PRIO_LEVELS = 8;
   localparam int TID_W       = $clog2(TASK_SLOTS);
   localparam int LVL_W       = $clog2(PRIO_LEVELS);
   localparam int CNT_W       = $clog2(TASK_SLOTS + 1);

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_READY  = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_NEXT   = 2'd3;

   localparam logic [2:0] KIND_DONE     = 3'd0;
   localparam logic [2:0] KIND_REAPED   = 3'd1;
   localparam logic [2:0] KIND_SWITCH   = 3'd2;
   localparam logic [2:0] KIND_DISPATCH = 3'd3;
   localparam logic [2:0] KIND_IDLE     = 3'd4;

   typedef struct packed {
      logic [1:0] opcode;
      logic [3:0] task_id;
      logic [2:0] task_prio;
      logic       current_valid;
      logic [3:0] current_id;
      logic       current_running;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] result_task;
      logic       interrupt;
      logic       preempted;
      logic       last;
   } rsp_type;

   // Decoded command handed from the front end to the engine
   typedef struct packed {
      logic [1:0]       opcode;
      logic             tok;
      logic [TID_W-1:0] tid;
      logic [LVL_W-1:0] lvl;
      logic             have_cur;
      logic [TID_W-1:0] cid;
      logic             crun;
   } cmd_type;

   localparam int CQ_DEPTH = 2;

endpackage

### rtl/pts_front.sv
// ----------------------------------------------------------------------------
// pts_front: request decode and command queue
// Classifies each request transaction and holds it in a short queue.
// ----------------------------------------------------------------------------
module pts_front import pts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_take,
   output cmd_type cmd_data
);

   cmd_type    q_ff [CQ_DEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   cmd_type    dec;
   logic       push, pop;

   // Decode ranges and saturate the level
   always_comb begin
      dec.opcode   = req_data.opcode;
      dec.tok      = ({28'd0, req_data.task_id} < TASK_SLOTS);
      dec.tid      = req_data.task_id[TID_W-1:0];
      dec.lvl      = ({29'd0, req_data.task_prio} >= PRIO_LEVELS) ?
                     LVL_W'(PRIO_LEVELS - 1) : req_data.task_prio[LVL_W-1:0];
      dec.have_cur = req_data.current_valid &&
                     ({28'd0, req_data.current_id} < TASK_SLOTS);
      dec.cid      = req_data.current_id[TID_W-1:0];
      dec.crun     = req_data.current_running;
   end

   assign req_stall = (cnt_ff == 2'(CQ_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd_data  = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= dec;
   end

endmodule

### rtl/pts_engine.sv
// ----------------------------------------------------------------------------
// pts_engine: ready-list engine
// Carries out one command at a time and emits results.
// ----------------------------------------------------------------------------
module pts_engine import pts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_take,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_REAP  = 5'b00010,
      S_PICK  = 5'b00100,
      S_UNLK  = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;

   logic [LVL_W-1:0] lvl_ff [TASK_SLOTS];
   logic [TASK_SLOTS-1:0] act_ff, que_ff, pend_ff;
   logic [TID_W-1:0] nxt_ff [TASK_SLOTS];
   logic [TID_W-1:0] prv_ff [TASK_SLOTS];
   logic [TID_W-1:0] hd_ff [PRIO_LEVELS];
   logic [TID_W-1:0] tl_ff [PRIO_LEVELS];
   logic [PRIO_LEVELS-1:0] mask_ff;
   logic [TID_W-1:0] rf_ff [TASK_SLOTS];
   logic [TID_W-1:0] rh_ff, rt_ff;
   logic [CNT_W-1:0] rc_ff;

   logic [TID_W-1:0] utask_ff, utask_in;   // task to unlink
   logic             upre_ff, upre_in;
   logic             ureap_ff, ureap_in;
   logic             out_v_ff, out_v_in;
   rsp_type          out_ff, out_in;

   // Working copies for the combinational update
   logic [TASK_SLOTS-1:0] act_in, que_in, pend_in;
   logic [PRIO_LEVELS-1:0] mask_in;
   logic [TID_W-1:0] rh_in, rt_in;
   logic [CNT_W-1:0] rc_in;
   logic             lvl_we, rf_we;
   logic [LVL_W-1:0] lvl_wd;
   // enqueue request
   logic             enq;
   logic [TID_W-1:0] enq_t;
   // unlink request
   logic             unl;

   logic [LVL_W-1:0] best;
   logic             running;
   logic             out_free;
   logic [TID_W-1:0] r;

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_v_ff || !rsp_stall;
   assign r         = rf_ff[rh_ff];

   // Priority encoder over the ready mask
   always_comb begin
      best = '0;
      for (int i = PRIO_LEVELS - 1; i >= 0; i--) begin
         if (mask_ff[i]) best = LVL_W'(i);
      end
   end

   assign running = cmd_ff.have_cur && cmd_ff.crun && act_ff[cmd_ff.cid] &&
                    !que_ff[cmd_ff.cid];

   // Control and scalar state
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      act_in   = act_ff;
      que_in   = que_ff;
      pend_in  = pend_ff;
      rh_in    = rh_ff;
      rt_in    = rt_ff;
      rc_in    = rc_ff;
      utask_in = utask_ff;
      upre_in  = upre_ff;
      ureap_in = ureap_ff;
      lvl_we   = 1'b0;
      lvl_wd   = cmd_ff.lvl;
      rf_we    = 1'b0;
      enq      = 1'b0;
      enq_t    = cmd_ff.tid;
      unl      = 1'b0;
      cmd_take = 1'b0;
      out_v_in = out_v_ff && rsp_stall;
      out_in   = out_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in   = cmd_data;
               state_in = (cmd_data.opcode == OP_NEXT) ? S_REAP : S_EMIT;
            end
         end
         S_EMIT: begin
            // Add, ready or remove: one done result
            if (out_free) begin
               out_v_in       = 1'b1;
               out_in         = '0;
               out_in.kind    = KIND_DONE;
               out_in.last    = 1'b1;
               state_in       = S_IDLE;
               unique case (cmd_ff.opcode)
                  OP_ADD: begin
                     if (cmd_ff.tok && !act_ff[cmd_ff.tid] && !pend_ff[cmd_ff.tid]) begin
                        lvl_we = 1'b1;
                        act_in[cmd_ff.tid] = 1'b1;
                        enq = 1'b1;
                        out_in.interrupt = !cmd_ff.have_cur ||
                           (cmd_ff.lvl < ((cmd_ff.cid == cmd_ff.tid) ?
                                          cmd_ff.lvl : lvl_ff[cmd_ff.cid]));
                     end
                  end
                  OP_READY: begin
                     if (cmd_ff.tok && act_ff[cmd_ff.tid] && !que_ff[cmd_ff.tid]) begin
                        enq = 1'b1;
                        out_in.interrupt = !cmd_ff.have_cur ||
                           (lvl_ff[cmd_ff.tid] < lvl_ff[cmd_ff.cid]);
                     end
                  end
                  OP_REMOVE: begin
                     if (cmd_ff.tok && act_ff[cmd_ff.tid]) begin
                        act_in[cmd_ff.tid]  = 1'b0;
                        pend_in[cmd_ff.tid] = 1'b1;
                        rf_we = 1'b1;
                        rt_in = rt_ff + 1'b1;
                        rc_in = rc_ff + 1'b1;
                        out_in.interrupt = cmd_ff.have_cur &&
                           (cmd_ff.cid == cmd_ff.tid) && cmd_ff.crun;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_REAP: begin
            // Walk the removal queue, one entry per result
            if (out_free) begin
               if (rc_ff != '0) begin
                  if (cmd_ff.have_cur && r == cmd_ff.cid) begin
                     out_v_in = 1'b1;
                     out_in   = '0;
                     out_in.kind = KIND_SWITCH;
                     out_in.last = 1'b1;
                     state_in = S_IDLE;
                  end else if (que_ff[r]) begin
                     utask_in = r;
                     ureap_in = 1'b1;
                     upre_in  = 1'b0;
                     state_in = S_UNLK;
                  end else begin
                     pend_in[r] = 1'b0;
                     rh_in = rh_ff + 1'b1;
                     rc_in = rc_ff - 1'b1;
                     out_v_in = 1'b1;
                     out_in   = '0;
                     out_in.kind = KIND_REAPED;
                     out_in.result_task = r;
                  end
               end else begin
                  state_in = S_PICK;
               end
            end
         end
         S_PICK: begin
            if (out_free) begin
               out_in = '0;
               out_in.kind = KIND_DISPATCH;
               out_in.last = 1'b1;
               if (mask_ff == '0) begin
                  out_v_in = 1'b1;
                  state_in = S_IDLE;
                  if (running) out_in.result_task = cmd_ff.cid;
                  else out_in.kind = KIND_IDLE;
               end else if (running && lvl_ff[cmd_ff.cid] <= best) begin
                  out_v_in = 1'b1;
                  state_in = S_IDLE;
                  out_in.result_task = cmd_ff.cid;
               end else begin
                  // Push back the running task first, then unlink the head
                  utask_in = hd_ff[best];
                  ureap_in = 1'b0;
                  upre_in  = running;
                  if (running) begin
                     enq   = 1'b1;
                     enq_t = cmd_ff.cid;
                  end
                  state_in = S_UNLK;
               end
            end
         end
         S_UNLK: begin
            if (out_free) begin
               unl = 1'b1;
               out_v_in = 1'b1;
               out_in   = '0;
               out_in.result_task = utask_ff;
               if (ureap_ff) begin
                  pend_in[utask_ff] = 1'b0;
                  rh_in = rh_ff + 1'b1;
                  rc_in = rc_ff - 1'b1;
                  out_in.kind = KIND_REAPED;
                  state_in = S_REAP;
               end else begin
                  out_in.kind = KIND_DISPATCH;
                  out_in.preempted = upre_ff;
                  out_in.last = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (enq) que_in[enq_t] = 1'b1;
      if (unl) que_in[utask_ff] = 1'b0;
   end

   // Ready-list link updates
   logic [LVL_W-1:0] elv, ulv;
   logic             u_hd, u_tl;
   logic [TID_W-1:0] up, un;
   assign elv  = lvl_we ? lvl_wd : lvl_ff[enq_t];
   assign ulv  = lvl_ff[utask_ff];
   assign u_hd = (hd_ff[ulv] == utask_ff);
   assign u_tl = (tl_ff[ulv] == utask_ff);
   assign up   = prv_ff[utask_ff];
   assign un   = nxt_ff[utask_ff];

   always_comb begin
      mask_in = mask_ff;
      if (enq) mask_in[elv] = 1'b1;
      if (unl && u_hd && u_tl) mask_in[ulv] = 1'b0;
   end

   // Hold array contents
   always_ff @(posedge clock) begin
      if (rf_we) rf_ff[rt_ff] <= cmd_ff.tid;
      if (enq) begin
         if (mask_ff[elv]) begin
            nxt_ff[tl_ff[elv]] <= enq_t;
            prv_ff[enq_t] <= tl_ff[elv];
         end else begin
            hd_ff[elv] <= enq_t;
            prv_ff[enq_t] <= enq_t;
         end
         nxt_ff[enq_t] <= enq_t;
         tl_ff[elv] <= enq_t;
      end
      if (unl) begin
         if (u_hd && u_tl) begin
         end else if (u_hd) begin
            hd_ff[ulv] <= un;
         end else if (u_tl) begin
            tl_ff[ulv] <= up;
            nxt_ff[up] <= up;
         end else begin
            nxt_ff[up] <= un;
            prv_ff[un] <= up;
         end
      end
      cmd_ff   <= cmd_in;
      utask_ff <= utask_in;
      upre_ff  <= upre_in;
      ureap_ff <= ureap_in;
      out_ff   <= out_in;
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         act_ff   <= '0;
         que_ff   <= '0;
         pend_ff  <= '0;
         mask_ff  <= '0;
         rh_ff    <= '0;
         rt_ff    <= '0;
         rc_ff    <= '0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < TASK_SLOTS; i++) lvl_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
         que_ff   <= que_in;
         pend_ff  <= pend_in;
         mask_ff  <= mask_in;
         rh_ff    <= rh_in;
         rt_ff    <= rt_in;
         rc_ff    <= rc_in;
         out_v_ff <= out_v_in;
         if (lvl_we) lvl_ff[cmd_ff.tid] <= lvl_wd;
      end
   end

endmodule

### rtl/priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler: preemptive bitmap scheduler, FIFO per level
// Front decode queue feeding a sequential ready-list engine.
// ----------------------------------------------------------------------------
// The engine takes each command in its idle state. Add, ready and remove
// then give one done transaction from the emit state. Get-next walks the
// removal queue: a reaped task that is not queued gives its result in the
// reap state, one still in a ready list is unlinked first in the unlink
// state. It ends with a switch-stack transaction, an idle or kept-task
// dispatch from the pick state, or a dispatch that unlinks a ready-list
// head in the unlink state, over the engine's single link-array update path.
// A two-entry command queue lets requests be taken while the engine is busy.
module priority_task_scheduler import pts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    cmd_valid, cmd_take;
   cmd_type cmd_data;

   pts_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_take, .cmd_data
   );

   pts_engine u_engine (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

### rtl/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker: port-level checks of the scheduler
// Result stability and result field rules.
// ----------------------------------------------------------------------------
module pts_checker import pts_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Interrupt only on done results
   a_intr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.interrupt |-> rsp_data.kind == KIND_DONE)
      else $error("interrupt on non-done result");

   // Preempt only on dispatch
   a_pre: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.preempted |-> rsp_data.kind == KIND_DISPATCH)
      else $error("preempted on non-dispatch result");

   // Only reap results may be non-final
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.kind == KIND_REAPED)
      else $error("non-final result of wrong kind");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_data
);
